// ===== rtl/core/npm_pkg.sv =====
// Shared constants, codes and types of the nine-patch mesh vertex generator.
package npm_pkg;

   localparam int MAX_DIVS   = 6;
   localparam int CNT_W      = $clog2(MAX_DIVS + 1);
   localparam int IDX_W      = $clog2(MAX_DIVS);
   localparam int COL_W      = $clog2(MAX_DIVS + 2);
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = $clog2(QDEPTH + 1);
   localparam int PIX_W      = 12;
   localparam int POS_W      = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int FACTOR_W   = 32;
   localparam int DIV_NUM_W  = 32;
   localparam int DIV_DEN_W  = 14;

   typedef enum logic [1:0] {
      OP_LOAD_X = 2'd0,
      OP_LOAD_Y = 2'd1,
      OP_GEN    = 2'd2
   } op_type;

   localparam logic [1:0] REQ_NONE = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_DST_LEFT   = 3'd2,
      CSR_DST_TOP    = 3'd3,
      CSR_DST_RIGHT  = 3'd4,
      CSR_DST_BOTTOM = 3'd5
   } csr_type;

   typedef struct packed {
      op_type            op;
      logic [PIX_W-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic [PIX_W-1:0] src_width;
      logic [PIX_W-1:0] src_height;
      logic [POS_W-1:0] dst_left;
      logic [POS_W-1:0] dst_top;
      logic [POS_W-1:0] dst_right;
      logic [POS_W-1:0] dst_bottom;
   } cfg_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
   } front_stat_type;

   typedef struct packed {
      logic idle;
      logic emitting;
   } back_stat_type;

endpackage

// ===== rtl/core/npm_front.sv =====
// Front end: accepts request beats, drops unused codes and queues commands.
module npm_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic [npm_pkg::PIX_W-1:0]     req_div_value,
   output logic                          cmd_valid,
   output npm_pkg::cmd_type              cmd,
   input  logic                          cmd_ready,
   output npm_pkg::front_stat_type       stat
);

   npm_pkg::cmd_type                q_mem_ff [npm_pkg::QDEPTH];
   logic [npm_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [npm_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [npm_pkg::QCNT_W-1:0]      count_ff;
   logic                            full;
   logic                            push;
   logic                            pop;
   npm_pkg::cmd_type                push_cmd;

   assign full      = (count_ff == npm_pkg::QCNT_W'(npm_pkg::QDEPTH));
   assign req_ready = !full;
   assign push      = req_valid && req_ready && (req_type != npm_pkg::REQ_NONE);
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_mem_ff[rd_ptr_ff];

   assign push_cmd.op    = npm_pkg::op_type'(req_type);
   assign push_cmd.value = req_div_value;

   assign stat.count = count_ff;
   assign stat.full  = full;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + npm_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + npm_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + npm_pkg::QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - npm_pkg::QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/npm_div.sv =====
// Restoring divider, one quotient bit per cycle.
module npm_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [npm_pkg::DIV_NUM_W-1:0]   num,
   input  logic [npm_pkg::DIV_DEN_W-1:0]   den,
   output logic                            done,
   output logic [npm_pkg::DIV_NUM_W-1:0]   quo
);

   localparam int STEP_W = $clog2(npm_pkg::DIV_NUM_W);

   logic [npm_pkg::DIV_NUM_W-1:0]  quo_ff;
   logic [npm_pkg::DIV_DEN_W-1:0]  rem_ff;
   logic [npm_pkg::DIV_DEN_W-1:0]  den_ff;
   logic [STEP_W-1:0]              step_ff;
   logic                           busy_ff;
   logic                           done_ff;
   logic [npm_pkg::DIV_DEN_W:0]    trial;
   logic [npm_pkg::DIV_DEN_W:0]    diff;
   logic                           fits;
   logic                           last_step;

   assign trial     = {rem_ff, quo_ff[npm_pkg::DIV_NUM_W-1]};
   assign fits      = (trial >= {1'b0, den_ff});
   assign diff      = trial - {1'b0, den_ff};
   assign last_step = busy_ff && (step_ff == STEP_W'(npm_pkg::DIV_NUM_W - 1));
   assign done      = done_ff;
   assign quo       = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= !start && last_step;
         if (start) begin
            quo_ff  <= num;
            rem_ff  <= '0;
            den_ff  <= den;
            step_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff  <= fits ? diff[npm_pkg::DIV_DEN_W-1:0] : trial[npm_pkg::DIV_DEN_W-1:0];
            quo_ff  <= {quo_ff[npm_pkg::DIV_NUM_W-2:0], fits};
            step_ff <= step_ff + STEP_W'(1);
            if (last_step) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

endmodule

// ===== rtl/core/npm_back.sv =====
// Back end: division stores, stretch factors, column table and vertex emission.
module npm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  npm_pkg::cfg_type                  cfg,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  npm_pkg::cmd_type                  cmd,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [npm_pkg::POS_W-1:0]  rsp_vertex_x,
   output logic signed [npm_pkg::POS_W-1:0]  rsp_vertex_y,
   output logic [npm_pkg::PIX_W-1:0]         rsp_tex_u,
   output logic [npm_pkg::PIX_W-1:0]         rsp_tex_v,
   output logic                              rsp_last_vertex,
   output npm_pkg::back_stat_type            stat
);

   localparam int PW = npm_pkg::PIX_W;
   localparam int QW = npm_pkg::POS_W;
   localparam int CW = npm_pkg::CNT_W;
   localparam int KW = npm_pkg::COL_W;
   localparam int IW = npm_pkg::IDX_W;
   localparam logic signed [39:0] POS_MAX = 40'sd8388607;
   localparam logic signed [39:0] POS_MIN = -40'sd8388608;

   typedef enum logic [3:0] {
      S_IDLE, S_TRIM_S, S_TRIM_E, S_SUM_X, S_DIV_X, S_SUM_Y, S_DIV_Y, S_COL, S_EMIT, S_ROW
   } state_type;

   state_type                    state_ff;
   logic [PW-1:0]                x_store_ff [npm_pkg::MAX_DIVS];
   logic [PW-1:0]                y_store_ff [npm_pkg::MAX_DIVS];
   logic [CW-1:0]                x_cnt_ff, y_cnt_ff, nx_ff, ny_ff;
   logic [CW-1:0]                idx_ff, ys_ff, ye_ff;
   logic signed [14:0]           ss_ff;
   logic [PW-1:0]                prev_ff;
   logic [npm_pkg::FACTOR_W-1:0] stretch_x_ff, stretch_y_ff;
   logic signed [QW-1:0]         pos_ff, row_pos_ff;
   logic signed [QW-1:0]         xs_ff [npm_pkg::MAX_DIVS + 2];
   logic [PW-1:0]                us_ff [npm_pkg::MAX_DIVS + 2];
   logic [PW-1:0]                tv_ff;
   logic                         last_row_ff;
   logic [KW-1:0]                col_ff;
   logic                         div_start_ff, div_shrink_ff;
   logic [npm_pkg::DIV_NUM_W-1:0] div_num_ff;
   logic [npm_pkg::DIV_DEN_W-1:0] div_den_ff;
   logic                         div_done;
   logic [npm_pkg::DIV_NUM_W-1:0] div_quo;
   logic                         rsp_valid_ff;
   logic signed [QW-1:0]         rsp_x_ff, rsp_y_ff;
   logic [PW-1:0]                rsp_u_ff, rsp_v_ff;
   logic                         rsp_last_ff;

   logic signed [QW-1:0]         left, top, right, bottom;
   logic signed [24:0]           ext_w, ext_h;
   logic                         empty;
   logic [CW-1:0]                ye_m1, rel, ny_eff;
   logic [PW-1:0]                x_rd, y_rd, rd_sel;
   logic signed [12:0]           seg;
   logic                         sel_y, stretchy;
   logic [CW-1:0]                n_sel;
   logic [PW-1:0]                size_sel;
   logic signed [25:0]           ext_sel, fx256, grow_num;
   logic signed [15:0]           fixed_sz;
   logic                         grow, skip;
   logic                         in_sum, sum_more, emit_now;
   logic [npm_pkg::DIV_NUM_W-1:0] set_num;
   logic [npm_pkg::DIV_DEN_W-1:0] set_den;
   logic [npm_pkg::FACTOR_W-1:0] div_factor, f_sel;
   logic signed [39:0]           delta, acc40;
   logic signed [QW-1:0]         acc, new_pos;
   logic                         out_free;
   logic [KW-1:0]                last_col;
   logic signed [QW-1:0]         emit_x;
   logic [PW-1:0]                emit_u;

   function automatic logic signed [39:0] axis_delta(input logic signed [12:0] s,
                                                      input logic st,
                                                      input logic [31:0] f);
      logic signed [12:0] neg;
      logic [11:0]        a;
      logic [42:0]        prod;
      logic signed [39:0] p;
      logic signed [39:0] sc;
      logic signed [39:0] fixd;
      neg  = -s;
      a    = s[12] ? neg[11:0] : s[11:0];
      prod = {31'd0, a} * {12'd0, f[30:0]};
      p    = $signed({3'd0, prod[42:6]});
      sc   = s[12] ? -p : p;
      fixd = {{19{s[12]}}, s, 8'd0};
      if (f[31]) begin
         return st ? 40'sd0 : sc;
      end
      return st ? sc : fixd;
   endfunction

   npm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign left   = $signed(cfg.dst_left);
   assign top    = $signed(cfg.dst_top);
   assign right  = $signed(cfg.dst_right);
   assign bottom = $signed(cfg.dst_bottom);
   assign ext_w  = $signed({right[QW-1], right}) - $signed({left[QW-1], left});
   assign ext_h  = $signed({bottom[QW-1], bottom}) - $signed({top[QW-1], top});
   assign empty  = (ext_w <= 25'sd0) || (ext_h <= 25'sd0) ||
                   (cfg.src_width == '0) || (cfg.src_height == '0);

   assign ye_m1  = ye_ff - CW'(1);
   assign rel    = idx_ff - ys_ff;
   assign ny_eff = ye_ff - ys_ff;
   assign x_rd   = x_store_ff[idx_ff[IW-1:0]];
   assign y_rd   = y_store_ff[(state_ff == S_TRIM_E) ? ye_m1[IW-1:0] : idx_ff[IW-1:0]];

   assign sel_y    = (state_ff == S_SUM_Y) || (state_ff == S_ROW);
   assign rd_sel   = sel_y ? y_rd : x_rd;
   assign seg      = $signed({1'b0, rd_sel}) - $signed({1'b0, prev_ff});
   assign stretchy = sel_y ? rel[0] : idx_ff[0];

   // Factor setup for the axis whose segment sum just finished.
   assign n_sel    = sel_y ? ny_eff : nx_ff;
   assign size_sel = sel_y ? cfg.src_height : cfg.src_width;
   assign ext_sel  = sel_y ? {ext_h[24], ext_h} : {ext_w[24], ext_w};
   assign fixed_sz = $signed({4'd0, size_sel}) - $signed({ss_ff[14], ss_ff});
   assign fx256    = {{2{fixed_sz[15]}}, fixed_sz, 8'd0};
   assign grow     = (ext_sel >= fx256);
   assign grow_num = ext_sel - fx256;
   assign skip     = (n_sel == '0) || (grow && (ss_ff[14] || (ss_ff == '0)));
   assign set_num  = grow ? {grow_num, 6'd0} : {ext_sel, 6'd0};
   assign set_den  = grow ? ss_ff[npm_pkg::DIV_DEN_W-1:0] : fixed_sz[npm_pkg::DIV_DEN_W-1:0];
   assign div_factor = {div_shrink_ff, (div_quo[31] ? 31'h7FFF_FFFF : div_quo[30:0])};

   // A sum state either takes one more division, skips the divider or starts it.
   assign in_sum   = (state_ff == S_SUM_X) || (state_ff == S_SUM_Y);
   assign sum_more = (state_ff == S_SUM_X) ? (idx_ff < nx_ff) : (idx_ff != ye_ff);

   // Shared scaler for column and row positions.
   assign f_sel   = sel_y ? stretch_y_ff : stretch_x_ff;
   assign acc     = sel_y ? row_pos_ff : pos_ff;
   assign delta   = axis_delta(seg, stretchy, f_sel);
   assign acc40   = {{16{acc[QW-1]}}, acc} + delta;
   assign new_pos = (acc40 > POS_MAX) ? QW'(POS_MAX) :
                    (acc40 < POS_MIN) ? QW'(POS_MIN) : acc40[QW-1:0];

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit_now = (state_ff == S_EMIT) && out_free;
   assign last_col = KW'(nx_ff) + KW'(1);
   assign emit_x   = (col_ff == '0) ? left : xs_ff[col_ff];
   assign emit_u   = (col_ff == '0) ? '0 : us_ff[col_ff];

   assign cmd_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_vertex_x    = rsp_x_ff;
   assign rsp_vertex_y    = rsp_y_ff;
   assign rsp_tex_u       = rsp_u_ff;
   assign rsp_tex_v       = rsp_v_ff;
   assign rsp_last_vertex = rsp_last_ff;
   assign stat.idle       = (state_ff == S_IDLE);
   assign stat.emitting   = (state_ff == S_EMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         x_cnt_ff     <= '0;
         y_cnt_ff     <= '0;
         stretch_x_ff <= '0;
         stretch_y_ff <= '0;
         row_pos_ff   <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= in_sum && !sum_more && !skip;
         if (emit_now) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  unique case (cmd.op)
                     npm_pkg::OP_LOAD_X: begin
                        if (x_cnt_ff < CW'(npm_pkg::MAX_DIVS)) begin
                           x_store_ff[x_cnt_ff[IW-1:0]] <= cmd.value;
                           x_cnt_ff <= x_cnt_ff + CW'(1);
                        end
                     end
                     npm_pkg::OP_LOAD_Y: begin
                        if (y_cnt_ff < CW'(npm_pkg::MAX_DIVS)) begin
                           y_store_ff[y_cnt_ff[IW-1:0]] <= cmd.value;
                           y_cnt_ff <= y_cnt_ff + CW'(1);
                        end
                     end
                     npm_pkg::OP_GEN: begin
                        nx_ff    <= x_cnt_ff;
                        ny_ff    <= y_cnt_ff;
                        x_cnt_ff <= '0;
                        y_cnt_ff <= '0;
                        idx_ff   <= '0;
                        if (!empty) begin
                           state_ff <= S_TRIM_S;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_TRIM_S: begin
               if ((idx_ff < ny_ff) && (y_rd == '0)) begin
                  idx_ff <= idx_ff + CW'(1);
               end else begin
                  ys_ff    <= idx_ff;
                  ye_ff    <= ny_ff;
                  state_ff <= S_TRIM_E;
               end
            end
            S_TRIM_E: begin
               if ((ye_ff > ys_ff) && (y_rd == cfg.src_height)) begin
                  ye_ff <= ye_m1;
               end else begin
                  idx_ff   <= '0;
                  ss_ff    <= '0;
                  prev_ff  <= '0;
                  state_ff <= S_SUM_X;
               end
            end
            S_SUM_X, S_SUM_Y: begin
               if (sum_more) begin
                  if (stretchy) begin
                     ss_ff <= ss_ff + {{2{seg[12]}}, seg};
                  end
                  prev_ff <= rd_sel;
                  idx_ff  <= idx_ff + CW'(1);
               end else if (skip) begin
                  prev_ff <= '0;
                  if (state_ff == S_SUM_X) begin
                     stretch_x_ff <= '0;
                     idx_ff       <= ys_ff;
                     ss_ff        <= '0;
                     state_ff     <= S_SUM_Y;
                  end else begin
                     stretch_y_ff <= '0;
                     idx_ff       <= '0;
                     pos_ff       <= left;
                     state_ff     <= S_COL;
                  end
               end else begin
                  div_num_ff    <= set_num;
                  div_den_ff    <= set_den;
                  div_shrink_ff <= !grow;
                  state_ff      <= (state_ff == S_SUM_X) ? S_DIV_X : S_DIV_Y;
               end
            end
            S_DIV_X: begin
               if (div_done) begin
                  stretch_x_ff <= div_factor;
                  idx_ff       <= ys_ff;
                  ss_ff        <= '0;
                  prev_ff      <= '0;
                  state_ff     <= S_SUM_Y;
               end
            end
            S_DIV_Y: begin
               if (div_done) begin
                  stretch_y_ff <= div_factor;
                  idx_ff       <= '0;
                  prev_ff      <= '0;
                  pos_ff       <= left;
                  state_ff     <= S_COL;
               end
            end
            S_COL: begin
               if (idx_ff < nx_ff) begin
                  xs_ff[KW'(idx_ff) + KW'(1)] <= new_pos;
                  us_ff[KW'(idx_ff) + KW'(1)] <= x_rd;
                  pos_ff  <= new_pos;
                  prev_ff <= x_rd;
                  idx_ff  <= idx_ff + CW'(1);
               end else begin
                  xs_ff[last_col] <= right;
                  us_ff[last_col] <= cfg.src_width;
                  row_pos_ff  <= top;
                  tv_ff       <= '0;
                  last_row_ff <= 1'b0;
                  col_ff      <= '0;
                  idx_ff      <= ys_ff;
                  prev_ff     <= '0;
                  state_ff    <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_x_ff     <= emit_x;
                  rsp_y_ff     <= row_pos_ff;
                  rsp_u_ff     <= emit_u;
                  rsp_v_ff     <= tv_ff;
                  rsp_last_ff  <= last_row_ff && (col_ff == last_col);
                  if (col_ff == last_col) begin
                     col_ff   <= '0;
                     state_ff <= last_row_ff ? S_IDLE : S_ROW;
                  end else begin
                     col_ff <= col_ff + KW'(1);
                  end
               end
            end
            S_ROW: begin
               if (idx_ff != ye_ff) begin
                  row_pos_ff <= new_pos;
                  tv_ff      <= y_rd;
                  prev_ff    <= y_rd;
                  idx_ff     <= idx_ff + CW'(1);
               end else begin
                  row_pos_ff  <= bottom;
                  tv_ff       <= cfg.src_height;
                  last_row_ff <= 1'b1;
               end
               state_ff <= S_EMIT;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/core/nine_patch_mesh_vertex_gen.sv =====
// Top level of the nine-patch mesh vertex generator: registers, front, back.
//
//   Channel  Ports                         Direction  Beat carries
//   req      req_valid/req_ready           in         req_type, req_div_value
//   rsp      rsp_valid/rsp_ready           out        one mesh vertex
//   csr      csr_we/csr_index/csr_wdata    in         one register write
//
// A load beat is registered in the command queue on acceptance and is written
// to its store as the back end pops it, which it does only while idle. A
// generate beat first trims the y divisions, sums each axis, runs the shared
// 32-step divider once per axis that needs a factor, fills the column table,
// then emits one vertex per cycle while the result is not stalled, with a row
// step for the row position between rows.
// Reset is synchronous; it clears control state and sets the configuration registers to their defaults.
// A stalled result holds its output register while the four-entry command queue
// keeps taking request beats until it fills.
module nine_patch_mesh_vertex_gen (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_type,
   input  logic [npm_pkg::PIX_W-1:0]             req_div_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [npm_pkg::POS_W-1:0]      rsp_vertex_x,
   output logic signed [npm_pkg::POS_W-1:0]      rsp_vertex_y,
   output logic [npm_pkg::PIX_W-1:0]             rsp_tex_u,
   output logic [npm_pkg::PIX_W-1:0]             rsp_tex_v,
   output logic                                  rsp_last_vertex,
   input  logic                                  csr_we,
   input  logic [npm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [npm_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   npm_pkg::cfg_type         cfg_ff;
   logic                     cmd_valid;
   logic                     cmd_ready;
   npm_pkg::cmd_type         cmd;
   npm_pkg::front_stat_type  front_stat;
   npm_pkg::back_stat_type   back_stat;

   // Configuration registers. The register map follows the package enum.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= npm_pkg::PIX_W'(1);
         cfg_ff.src_height <= npm_pkg::PIX_W'(1);
         cfg_ff.dst_left   <= '0;
         cfg_ff.dst_top    <= '0;
         cfg_ff.dst_right  <= '0;
         cfg_ff.dst_bottom <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            npm_pkg::CSR_SRC_WIDTH:  cfg_ff.src_width  <= csr_wdata[npm_pkg::PIX_W-1:0];
            npm_pkg::CSR_SRC_HEIGHT: cfg_ff.src_height <= csr_wdata[npm_pkg::PIX_W-1:0];
            npm_pkg::CSR_DST_LEFT:   cfg_ff.dst_left   <= csr_wdata[npm_pkg::POS_W-1:0];
            npm_pkg::CSR_DST_TOP:    cfg_ff.dst_top    <= csr_wdata[npm_pkg::POS_W-1:0];
            npm_pkg::CSR_DST_RIGHT:  cfg_ff.dst_right  <= csr_wdata[npm_pkg::POS_W-1:0];
            npm_pkg::CSR_DST_BOTTOM: cfg_ff.dst_bottom <= csr_wdata[npm_pkg::POS_W-1:0];
            default: ;
         endcase
      end
   end

   npm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_div_value (req_div_value),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_ready     (cmd_ready),
      .stat          (front_stat)
   );

   npm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd_valid       (cmd_valid),
      .cmd_ready       (cmd_ready),
      .cmd             (cmd),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_vertex_x    (rsp_vertex_x),
      .rsp_vertex_y    (rsp_vertex_y),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_last_vertex (rsp_last_vertex),
      .stat            (back_stat)
   );

   // The result register comes out of reset empty.
   a_rsp_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat valid right after reset");

   // A new result beat only appears after the back end was emitting.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(back_stat.emitting))
      else $error("result beat raised outside emission");

   // The command queue never holds more than its depth.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      front_stat.count <= npm_pkg::QCNT_W'(npm_pkg::QDEPTH))
      else $error("command queue overfilled");

   // Commands leave the queue only into an idle back end.
   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd_ready) |=> !back_stat.emitting)
      else $error("command taken while emitting");

endmodule
